/* rtl/rfa_pkg.sv */
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants, command codes and sequencer states for the rational
// fraction ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package rfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  // magnitude of a product or of a sum of two products
  localparam int MAG_W         = 2 * OPERAND_WIDTH - 1;
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int CNT_W         = $clog2(MAG_W);
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 30;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_NORM = 3'd4;

  localparam logic [1:0] STEP_T1  = 2'd0;
  localparam logic [1:0] STEP_T2  = 2'd1;
  localparam logic [1:0] STEP_DEN = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/rfa_req_if.sv */
// ----------------------------------------------------------------------------
// rfa_req_if
// Operand channel: command and two fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfa_req_if;
  logic                                      valid;
  logic                                      ready;
  logic [2:0]                                cmd;
  logic signed [rfa_pkg::OPERAND_WIDTH-1:0]  a_num;
  logic [rfa_pkg::DEN_W-1:0]                 a_den;
  logic signed [rfa_pkg::OPERAND_WIDTH-1:0]  b_num;
  logic [rfa_pkg::DEN_W-1:0]                 b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

/* rtl/rfa_rsp_if.sv */
// ----------------------------------------------------------------------------
// rfa_rsp_if
// Result channel: reduced fraction and divide-by-zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfa_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rfa_pkg::RES_NUM_W-1:0]  res_num;
  logic [rfa_pkg::RES_DEN_W-1:0]         res_den;
  logic                                  div_zero;

  modport source (output valid, res_num, res_den, div_zero, input ready);
  modport sink   (input valid, res_num, res_den, div_zero, output ready);
endinterface

`default_nettype wire

/* rtl/rational_fraction_alu.sv */
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Add, subtract, multiply, divide or normalize fractions; result reduced to
// lowest terms with a positive denominator.
//
//   channel  dir  beat
//   req      in   cmd, a_num, a_den, b_num, b_den
//   rsp      out  res_num, res_den, div_zero
//
// One beat at a time. Three steps (T1, T2, DEN) on the shared 16x16 multiplier,
// a step to combine terms, then a binary GCD (one shift, swap or subtract per
// cycle) and two restoring divisions by the GCD on the same subtractor. A zero
// numerator or denominator skips the GCD and the divisions.
// rst is synchronous and leaves the block idle with no result pending.
// A finished result sits in the output register while the next beat is taken;
// the next result then waits in ST_DONE until that register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_fraction_alu (
  input  wire         clk,
  input  wire         rst,
  rfa_req_if.sink     req,
  rfa_rsp_if.source   rsp
);

  localparam int OW = rfa_pkg::OPERAND_WIDTH;
  localparam int MW = rfa_pkg::MAG_W;

  rfa_pkg::state_t state, state_next;

  logic [2:0]                   cmd_r;
  logic                         an_neg, bn_neg;
  logic [OW-1:0]                an_mag, bn_mag;
  logic [rfa_pkg::DEN_W-1:0]    ad, bd;
  logic [1:0]                   mul_step;

  logic                         is_add_sub, is_mul, is_div, is_norm;
  logic [OW-1:0]                mul_x, mul_y;
  logic [2*OW-1:0]              mul_p;

  logic [MW-1:0]                p_t1, p_t2, den_mag, num_mag;
  logic                         t2_neg, cmb_neg, den_neg;
  logic [MW-1:0]                cmb_mag;
  logic                         res_neg, zero_res, err;

  logic [MW-1:0]                u, v, g;
  logic [rfa_pkg::SHIFT_W-1:0]  k;

  logic [MW:0]                  sub_a, sub_b, sub_d;
  logic [MW:0]                  rem_sh;
  logic [MW-1:0]                rem, dvd, n_q;
  logic [rfa_pkg::CNT_W-1:0]    cnt;
  logic                         div_sel;
  logic                         div_last;
  logic                         q_bit;

  logic                         rsp_valid;
  logic signed [rfa_pkg::RES_NUM_W-1:0] res_num_r;
  logic [rfa_pkg::RES_DEN_W-1:0]        res_den_r;
  logic                                 div_zero_r;
  logic                                 out_load;
  logic [rfa_pkg::RES_NUM_W-1:0]        n_ext;

  // command decode; unused codes behave as normalize
  assign is_add_sub = (cmd_r == rfa_pkg::CMD_ADD) || (cmd_r == rfa_pkg::CMD_SUB);
  assign is_mul     = (cmd_r == rfa_pkg::CMD_MUL);
  assign is_div     = (cmd_r == rfa_pkg::CMD_DIV);
  assign is_norm    = (cmd_r >= rfa_pkg::CMD_NORM);

  // ---- shared multiplier operand select ----
  always_comb begin
    unique case (mul_step)
      rfa_pkg::STEP_T1: begin
        mul_x = an_mag;
        if (is_mul)       mul_y = bn_mag;
        else if (is_norm) mul_y = OW'(1);
        else              mul_y = OW'(bd);
      end
      rfa_pkg::STEP_T2: begin
        mul_x = bn_mag;
        mul_y = OW'(ad);
      end
      default: begin
        mul_x = OW'(ad);
        if (is_div)       mul_y = bn_mag;
        else if (is_norm) mul_y = OW'(1);
        else              mul_y = OW'(bd);
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // ---- signed combine of the two cross terms ----
  assign t2_neg = bn_neg ^ (cmd_r == rfa_pkg::CMD_SUB);

  always_comb begin
    den_neg = is_div ? bn_neg : 1'b0;
    if (is_add_sub) begin
      if (an_neg == t2_neg) begin
        cmb_neg = an_neg;
        cmb_mag = p_t1 + p_t2;
      end else if (p_t1 >= p_t2) begin
        cmb_neg = an_neg;
        cmb_mag = p_t1 - p_t2;
      end else begin
        cmb_neg = t2_neg;
        cmb_mag = p_t2 - p_t1;
      end
    end else begin
      cmb_neg = is_mul ? (an_neg ^ bn_neg) : an_neg;
      cmb_mag = p_t1;
    end
  end

  // ---- shared subtractor: GCD compare/subtract and division trial ----
  assign rem_sh = {rem, dvd[MW-1]};

  always_comb begin
    if (state == rfa_pkg::ST_DIV) begin
      sub_a = rem_sh;
      sub_b = {1'b0, g};
    end else begin
      sub_a = {1'b0, v};
      sub_b = {1'b0, u};
    end
  end

  assign sub_d    = sub_a - sub_b;
  assign q_bit    = !sub_d[MW];
  assign div_last = (cnt == rfa_pkg::CNT_W'(MW - 1));

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      rfa_pkg::ST_IDLE: if (req.valid) state_next = rfa_pkg::ST_MUL;
      rfa_pkg::ST_MUL:  if (mul_step == rfa_pkg::STEP_DEN) state_next = rfa_pkg::ST_COMB;
      rfa_pkg::ST_COMB: begin
        if (den_mag == '0 || cmb_mag == '0) state_next = rfa_pkg::ST_DONE;
        else                                state_next = rfa_pkg::ST_GCD;
      end
      rfa_pkg::ST_GCD:  if (v == '0) state_next = rfa_pkg::ST_DIV;
      rfa_pkg::ST_DIV:  if (div_last && div_sel) state_next = rfa_pkg::ST_DONE;
      rfa_pkg::ST_DONE: if (!rsp_valid || rsp.ready) state_next = rfa_pkg::ST_IDLE;
      default:          state_next = rfa_pkg::ST_IDLE;
    endcase
  end

  // ---- handshake outputs ----
  assign req.ready    = (state == rfa_pkg::ST_IDLE);
  assign out_load     = (state == rfa_pkg::ST_DONE) && (!rsp_valid || rsp.ready);
  assign rsp.valid    = rsp_valid;
  assign rsp.res_num  = res_num_r;
  assign rsp.res_den  = res_den_r;
  assign rsp.div_zero = div_zero_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfa_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // ---- datapath ----
  assign n_ext = zero_res ? '0 : rfa_pkg::RES_NUM_W'(n_q);

  always_ff @(posedge clk) begin
    unique case (state)
      rfa_pkg::ST_IDLE: begin
        cmd_r    <= req.cmd;
        an_neg   <= req.a_num[OW-1];
        an_mag   <= req.a_num[OW-1] ? OW'(-req.a_num) : OW'(req.a_num);
        bn_neg   <= req.b_num[OW-1];
        bn_mag   <= req.b_num[OW-1] ? OW'(-req.b_num) : OW'(req.b_num);
        ad       <= req.a_den;
        bd       <= req.b_den;
        mul_step <= rfa_pkg::STEP_T1;
      end
      rfa_pkg::ST_MUL: begin
        unique case (mul_step)
          rfa_pkg::STEP_T1: p_t1    <= mul_p[MW-1:0];
          rfa_pkg::STEP_T2: p_t2    <= mul_p[MW-1:0];
          default:          den_mag <= mul_p[MW-1:0];
        endcase
        mul_step <= mul_step + 2'd1;
      end
      rfa_pkg::ST_COMB: begin
        num_mag  <= cmb_mag;
        res_neg  <= cmb_neg ^ den_neg;
        zero_res <= (den_mag == '0) || (cmb_mag == '0);
        err      <= (den_mag == '0);
        u        <= cmb_mag;
        v        <= den_mag;
        k        <= '0;
      end
      rfa_pkg::ST_GCD: begin
        // binary GCD, one action per cycle
        priority if (v == '0) begin
          g       <= u << k;
          dvd     <= num_mag;
          rem     <= '0;
          cnt     <= '0;
          div_sel <= 1'b0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (sub_d[MW]) begin
          u <= v;
          v <= u;
        end else begin
          v <= sub_d[MW-1:0];
        end
      end
      rfa_pkg::ST_DIV: begin
        // restoring division, quotient shifts into dvd
        if (div_last && !div_sel) begin
          n_q     <= {dvd[MW-2:0], q_bit};
          dvd     <= den_mag;
          rem     <= '0;
          cnt     <= '0;
          div_sel <= 1'b1;
        end else begin
          rem <= q_bit ? sub_d[MW-1:0] : rem_sh[MW-1:0];
          dvd <= {dvd[MW-2:0], q_bit};
          cnt <= cnt + 1'b1;
        end
      end
      rfa_pkg::ST_DONE: begin
        if (out_load) begin
          res_num_r  <= res_neg ? -n_ext : n_ext;
          res_den_r  <= zero_res ? rfa_pkg::RES_DEN_W'(1) : rfa_pkg::RES_DEN_W'(dvd);
          div_zero_r <= err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rfa_checker.sv */
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks on the rational fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfa_checker (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  req_valid,
  input wire                                  req_ready,
  input wire                                  rsp_valid,
  input wire                                  rsp_ready,
  input wire signed [rfa_pkg::RES_NUM_W-1:0]  res_num,
  input wire [rfa_pkg::RES_DEN_W-1:0]         res_den,
  input wire                                  div_zero
);

  // a held result beat keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_num) && $stable(res_den)
                                 && $stable(div_zero))
    else $error("rsp beat changed while stalled");

  // one operand beat in flight: ready drops right after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req accepted again while busy");

  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && div_zero |-> res_num == 0 && res_den == 1)
    else $error("divide by zero not reported as 0/1");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> res_den != 0)
    else $error("zero denominator in result");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat right after reset");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .res_num   (rsp.res_num),
  .res_den   (rsp.res_den),
  .div_zero  (rsp.div_zero)
);

`default_nettype wire
